// ----- rtl/fbs_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and helpers of the float bit statistics block
package fbs_pkg;

	localparam int COUNT_BITS   = 31;
	localparam int WEIGHT_DEPTH = 512;
	localparam int EXP_DEPTH    = 256;
	localparam int MANT_BITS    = 23;
	localparam int MAG_W        = 31;
	localparam int IDX_W        = 9;
	localparam int EXP_AW       = $clog2(EXP_DEPTH);
	localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);
	localparam int MANT_AW      = $clog2(MANT_BITS);
	localparam int CLR_AW       = WEIGHT_AW;
	localparam int IN_DATA_W    = 48;
	localparam int IN_USER_W    = 4;
	localparam int OUT_DATA_W   = 280;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [MAG_W-1:0]      INF_MAG   = 31'h7F80_0000;
	localparam logic [EXP_AW-1:0]     EXP_SPECIAL = '1;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_READ   = 2'd1,
		MODE_WCLEAR = 2'd2,
		MODE_FCLEAR = 2'd3
	} mode_e_t;

	typedef enum logic [1:0] {
		TAB_EXP  = 2'd0,
		TAB_SEEN = 2'd1,
		TAB_SET  = 2'd2,
		TAB_MANT = 2'd3
	} table_e_t;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_ACCUM  = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_RDWAIT,
		ST_RDCAP,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 take;
		logic                 walk_rd;
		logic [MANT_AW-1:0]   step;
		logic                 rd_cap;
		logic                 clr_en;
		logic [CLR_AW-1:0]    clr_addr;
		logic                 out_load;
	} cmd_t;

	typedef struct packed {
		logic go_walk;
		logic go_read;
		logic go_clear;
	} status_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ----- rtl/fbs_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module fbs_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/fbs_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer: clearing sweep, mantissa walk, table read and result hand-off
module fbs_ctrl
	import fbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    m_tready,
	output logic    m_tvalid,
	input  status_t status,
	output cmd_t    cmd
);

	state_t             state_q, state_d;
	logic [MANT_AW-1:0] k_q, k_d;
	logic [CLR_AW-1:0]  c_q, c_d;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			k_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			c_q     <= c_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		c_d      = c_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.step     = k_q;
		cmd.clr_addr = c_q;
		unique case (state_q)
			ST_INIT, ST_SWEEP: begin
				cmd.clr_en = 1'b1;
				if (c_q == CLR_AW'(WEIGHT_DEPTH - 1)) begin
					c_d     = '0;
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end else begin
					c_d = c_q + 1'b1;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					k_d      = '0;
					c_d      = '0;
					priority if (status.go_walk) begin
						state_d = ST_WALK;
					end else if (status.go_read) begin
						state_d = ST_RDWAIT;
					end else if (status.go_clear) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_WALK: begin
				cmd.walk_rd = 1'b1;
				if (k_q == MANT_AW'(MANT_BITS - 1)) begin
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_DRAIN:  state_d = ST_DONE;
			ST_RDWAIT: state_d = ST_RDCAP;
			ST_RDCAP: begin
				cmd.rd_cap = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/fbs_datapath.sv -----
`timescale 1ns / 1ps
// counters, magnitude tracking, histogram memories and output register
module fbs_datapath
	import fbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic                  cfg_data,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic enable_q, accum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			accum_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data;
				REG_ACCUM:  accum_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// input decode
	mode_e_t          in_mode;
	logic [31:0]      in_bits;
	logic [EXP_AW-1:0] in_ex;
	logic [MANT_BITS-1:0] in_man;
	logic             in_special, in_zero, sample_ok;

	assign in_mode    = mode_e_t'(s_tuser[1:0]);
	assign in_bits    = s_tdata[31:0];
	assign in_ex      = in_bits[30:23];
	assign in_man     = in_bits[22:0];
	assign in_special = (in_ex == EXP_SPECIAL);
	assign in_zero    = (in_ex == '0) && (in_man == '0);

	logic [COUNT_BITS-1:0] zero_q, pos_q, nan_q, inf_q, den_q, acc_q, read_q;
	logic [MAG_W-1:0]      min_q, max_q;

	assign sample_ok       = enable_q && (acc_q != COUNT_MAX);
	assign status.go_walk  = (in_mode == MODE_SAMPLE) && sample_ok && !in_special && !in_zero;
	assign status.go_read  = (in_mode == MODE_READ);
	assign status.go_clear = (in_mode == MODE_FCLEAR) || ((in_mode == MODE_WCLEAR) && !accum_q);

	// item registers
	logic [EXP_AW-1:0]    ex_q;
	logic [MANT_BITS-1:0] man_q;
	logic                 normal_q;
	table_e_t             sel_q;
	logic [IDX_W-1:0]     idx_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ex_q     <= in_ex;
			man_q    <= in_man;
			normal_q <= (in_ex != '0);
			sel_q    <= table_e_t'(s_tuser[3:2]);
			idx_q    <= s_tdata[40:32];
		end
	end

	// scalar counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= '0;
			pos_q  <= '0;
			nan_q  <= '0;
			inf_q  <= '0;
			den_q  <= '0;
			acc_q  <= '0;
			min_q  <= INF_MAG;
			max_q  <= '0;
		end else if (cmd.take) begin
			unique case (in_mode)
				MODE_SAMPLE: begin
					if (sample_ok) begin
						acc_q <= acc_q + 1'b1;
						if (in_special) begin
							if (in_man == '0) inf_q <= sat_inc(inf_q);
							else nan_q <= sat_inc(nan_q);
						end else if (in_zero) begin
							zero_q <= sat_inc(zero_q);
						end else begin
							if (in_ex == '0) den_q <= sat_inc(den_q);
							if (!in_bits[31]) pos_q <= sat_inc(pos_q);
							if (in_ex != '0) begin
								if (in_bits[30:0] > max_q) max_q <= in_bits[30:0];
								if (in_bits[30:0] < min_q) min_q <= in_bits[30:0];
							end
						end
					end
				end
				MODE_READ: ;
				MODE_WCLEAR, MODE_FCLEAR: begin
					if (status.go_clear) begin
						zero_q <= '0;
						pos_q  <= '0;
						acc_q  <= '0;
						min_q  <= INF_MAG;
						max_q  <= '0;
					end
					if (in_mode == MODE_FCLEAR) begin
						nan_q <= '0;
						inf_q <= '0;
						den_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// mantissa walk, one position a cycle, each write in the cycle after its read
	logic [WEIGHT_AW-1:0] w;
	logic                 w_in;
	logic                 valid_s1, set_s1, win_s1;
	logic [MANT_AW-1:0]   k_s1;
	logic [WEIGHT_AW-1:0] w_s1;

	assign w    = WEIGHT_AW'(normal_q ? ex_q : EXP_AW'(1)) + WEIGHT_AW'(cmd.step);
	assign w_in = (32'(w) < WEIGHT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk_rd;
		end
	end

	always_ff @(posedge clk) begin
		k_s1   <= cmd.step;
		w_s1   <= w;
		win_s1 <= w_in;
		set_s1 <= man_q[cmd.step];
	end

	logic [COUNT_BITS-1:0] exp_rd, seen_rd, set_rd, mant_rd;
	logic                  exp_we, seen_we, set_we, mant_we;
	logic                  exp_upd, seen_upd, set_upd, mant_upd;

	assign exp_upd  = valid_s1 && (k_s1 == '0) && normal_q;
	assign seen_upd = valid_s1 && win_s1;
	assign set_upd  = valid_s1 && win_s1 && set_s1;
	assign mant_upd = valid_s1 && set_s1;

	assign exp_we  = exp_upd  || (cmd.clr_en && (cmd.clr_addr < CLR_AW'(EXP_DEPTH)));
	assign seen_we = seen_upd || cmd.clr_en;
	assign set_we  = set_upd  || cmd.clr_en;
	assign mant_we = mant_upd || (cmd.clr_en && (cmd.clr_addr < CLR_AW'(MANT_BITS)));

	fbs_ram #(.WIDTH(COUNT_BITS), .DEPTH(EXP_DEPTH)) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (cmd.clr_en ? cmd.clr_addr[EXP_AW-1:0] : ex_q),
		.wdata (cmd.clr_en ? '0 : sat_inc(exp_rd)),
		.raddr (cmd.walk_rd ? ex_q : idx_q[EXP_AW-1:0]),
		.rdata (exp_rd)
	);

	fbs_ram #(.WIDTH(COUNT_BITS), .DEPTH(WEIGHT_DEPTH)) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (cmd.clr_en ? cmd.clr_addr : w_s1),
		.wdata (cmd.clr_en ? '0 : sat_inc(seen_rd)),
		.raddr (cmd.walk_rd ? w : WEIGHT_AW'(idx_q)),
		.rdata (seen_rd)
	);

	fbs_ram #(.WIDTH(COUNT_BITS), .DEPTH(WEIGHT_DEPTH)) u_set_ram (
		.clk   (clk),
		.we    (set_we),
		.waddr (cmd.clr_en ? cmd.clr_addr : w_s1),
		.wdata (cmd.clr_en ? '0 : sat_inc(set_rd)),
		.raddr (cmd.walk_rd ? w : WEIGHT_AW'(idx_q)),
		.rdata (set_rd)
	);

	fbs_ram #(.WIDTH(COUNT_BITS), .DEPTH(MANT_BITS)) u_mant_ram (
		.clk   (clk),
		.we    (mant_we),
		.waddr (cmd.clr_en ? cmd.clr_addr[MANT_AW-1:0] : k_s1),
		.wdata (cmd.clr_en ? '0 : sat_inc(mant_rd)),
		.raddr (cmd.walk_rd ? cmd.step : idx_q[MANT_AW-1:0]),
		.rdata (mant_rd)
	);

	// read-back word, zero for anything but an in-range read
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			read_q <= '0;
		end else if (cmd.rd_cap) begin
			unique case (sel_q)
				TAB_EXP:  read_q <= (32'(idx_q) < EXP_DEPTH)    ? exp_rd  : '0;
				TAB_SEEN: read_q <= (32'(idx_q) < WEIGHT_DEPTH) ? seen_rd : '0;
				TAB_SET:  read_q <= (32'(idx_q) < WEIGHT_DEPTH) ? set_rd  : '0;
				TAB_MANT: read_q <= (32'(idx_q) < MANT_BITS)    ? mant_rd : '0;
				default:  read_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {1'b0, max_q, min_q, acc_q, den_q, inf_q, nan_q, pos_q, zero_q, read_q};
		end
	end

endmodule

// ----- rtl/float_bit_statistics.sv -----
`timescale 1ns / 1ps
// top level of the float bit statistics block
// Takes one 32-bit single-precision pattern (or a read, window clear or full
// reset command) per input word and returns one result word per input word
// with the read-back value and all class counters. A sample that needs the
// mantissa walk runs 23 read-modify-write steps on the histogram memories
// (one position a cycle), then a drain state for the last write, then loads
// the output register; infinity, NaN, zero, paused or limited samples go
// straight to the output load, a table read through a wait and a capture
// state. Window clear (when accumulate is off) and full reset sweep all
// histogram memories, one address a cycle. After reset the block runs the
// same clearing sweep before it accepts its first word; configuration writes
// are taken at any time. One word is handled at a time; a finished result
// waits in the output register while the next word is accepted, and the
// next output load waits until the receiver has taken that result.
module float_bit_statistics
	import fbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic                  cfg_index,  // 0 enable, 1 accumulate
	input  logic                  cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,    // sample_bits[31:0], entry_index[40:32]
	input  logic [IN_USER_W-1:0]  s_tuser,    // mode[1:0], table_select[3:2]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata     // read_value, zero_count, positive_count,
	                                          // nan_count, inf_count, denormal_count,
	                                          // sample_count, min_magnitude,
	                                          // max_magnitude, 31 bits each from bit 0
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	fbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	// counters, histograms and output word
	fbs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.status    (status),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- test/float_bit_statistics_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for the float bit statistics block
module float_bit_statistics_test;
	import fbs_pkg::*;

	// one result word, fields in port order
	typedef struct {
		logic [30:0] read_value;
		logic [30:0] zero_count;
		logic [30:0] positive_count;
		logic [30:0] nan_count;
		logic [30:0] inf_count;
		logic [30:0] denormal_count;
		logic [30:0] sample_count;
		logic [30:0] min_magnitude;
		logic [30:0] max_magnitude;
	} stats_t;

	// behavioural copy of the statistics engine plus the queue of predicted words
	class stats_scoreboard;
		logic [30:0] exp_hist[EXP_DEPTH];
		logic [30:0] seen_hist[WEIGHT_DEPTH];
		logic [30:0] set_hist[WEIGHT_DEPTH];
		logic [30:0] bit_hist[MANT_BITS];
		logic [30:0] zeros, positives, nans, infs, denormals, taken;
		logic [30:0] smallest, largest;
		logic enable_q, accum_q;
		stats_t pending[$];
		int mismatches;

		function void reset_all();
			enable_q = 1'b1;
			accum_q = 1'b0;
			clear_window();
			nans = '0;
			infs = '0;
			denormals = '0;
		endfunction

		function void clear_window();
			foreach (exp_hist[i]) exp_hist[i] = '0;
			foreach (seen_hist[i]) seen_hist[i] = '0;
			foreach (set_hist[i]) set_hist[i] = '0;
			foreach (bit_hist[i]) bit_hist[i] = '0;
			zeros = '0;
			positives = '0;
			taken = '0;
			smallest = INF_MAG;
			largest = '0;
		endfunction

		function logic [30:0] inc(logic [30:0] v);
			return (v == COUNT_MAX) ? v : v + 31'd1;
		endfunction

		function void write_reg(logic idx, logic val);
			if (idx == REG_ENABLE) enable_q = val;
			else accum_q = val;
		endfunction

		function void classify(logic [31:0] bits);
			logic [7:0] ex;
			logic [22:0] man;
			int base;
			ex = bits[30:23];
			man = bits[22:0];
			if (ex == 8'hFF) begin
				if (man == 0) infs = inc(infs);
				else nans = inc(nans);
				return;
			end
			if (ex == 0 && man == 0) begin
				zeros = inc(zeros);
				return;
			end
			if (ex == 0) denormals = inc(denormals);
			if (!bits[31]) positives = inc(positives);
			if (ex != 0) begin
				if (bits[30:0] > largest) largest = bits[30:0];
				if (bits[30:0] < smallest) smallest = bits[30:0];
				exp_hist[ex] = inc(exp_hist[ex]);
				base = ex;
			end else begin
				base = 1;
			end
			// weight walk over all mantissa positions
			for (int k = 0; k < MANT_BITS; k++) begin
				if (base + k < WEIGHT_DEPTH) begin
					seen_hist[base+k] = inc(seen_hist[base+k]);
					if (man[k]) set_hist[base+k] = inc(set_hist[base+k]);
				end
				if (man[k]) bit_hist[k] = inc(bit_hist[k]);
			end
		endfunction

		function void note_word(mode_e_t mode, logic [31:0] bits, table_e_t tab,
				logic [8:0] idx);
			stats_t s;
			s.read_value = '0;
			case (mode)
				MODE_SAMPLE: begin
					if (enable_q && taken != COUNT_MAX) begin
						classify(bits);
						taken = taken + 31'd1;
					end
				end
				MODE_READ: begin
					case (tab)
						TAB_EXP:  s.read_value = (idx < EXP_DEPTH) ? exp_hist[idx] : '0;
						TAB_SEEN: s.read_value = seen_hist[idx];
						TAB_SET:  s.read_value = set_hist[idx];
						default:  s.read_value = (idx < MANT_BITS) ? bit_hist[idx] : '0;
					endcase
				end
				MODE_WCLEAR: if (!accum_q) clear_window();
				default: begin
					clear_window();
					nans = '0;
					infs = '0;
					denormals = '0;
				end
			endcase
			s.zero_count = zeros;
			s.positive_count = positives;
			s.nan_count = nans;
			s.inf_count = infs;
			s.denormal_count = denormals;
			s.sample_count = taken;
			s.min_magnitude = smallest;
			s.max_magnitude = largest;
			pending.push_back(s);
		endfunction

		function void check_word(logic [OUT_DATA_W-1:0] d);
			stats_t e;
			logic [30:0] got[9];
			logic [30:0] want[9];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", d);
				return;
			end
			e = pending.pop_front();
			for (int f = 0; f < 9; f++) got[f] = d[f*31 +: 31];
			want = '{e.read_value, e.zero_count, e.positive_count, e.nan_count, e.inf_count,
				e.denormal_count, e.sample_count, e.min_magnitude, e.max_magnitude};
			for (int f = 0; f < 9; f++) begin
				if (got[f] !== want[f]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("field %0d mismatch: expected %h, got %h", f, want[f], got[f]);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic cfg_data = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	stats_scoreboard board = new();
	int burst_left = 0;
	bit stall_free = 1'b0;

	float_bit_statistics i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: stall pattern of its own, with a stall-free stretch on request
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_word(m_tdata);
		if (stall_free) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 9) < 6);
	end

	// send one word, with bursts and random gaps between them
	task automatic send_word(mode_e_t mode, logic [31:0] bits, table_e_t tab,
			logic [8:0] idx);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, idx, bits};
		s_tuser <= {tab, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_word(mode, bits, tab, idx);
		burst_left--;
		// drop valid only when a gap follows
		if (burst_left == 0) s_tvalid <= 1'b0;
	endtask

	task automatic sample(logic [31:0] bits);
		send_word(MODE_SAMPLE, bits, table_e_t'($urandom_range(0, 3)), 9'($urandom));
	endtask

	task automatic read_entry(table_e_t tab, logic [8:0] idx);
		send_word(MODE_READ, $urandom, tab, idx);
	endtask

	// hold off until every predicted word has come back, then the block is idle
	task automatic drain();
		if (s_tvalid) begin
			@(posedge clk);
			s_tvalid <= 1'b0;
		end
		burst_left = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, val);
	endtask

	// mostly finite values with a random exponent, sometimes special classes
	function automatic logic [31:0] random_float();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'hFF;
			1: v[30:23] = 8'h00;
			2: v[30:0] = '0;
			3: v[22:0] = (v[0]) ? '0 : v[22:0];
			default: ;
		endcase
		return v;
	endfunction

	task automatic random_phase(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70) sample(random_float());
			else if (r < 94) read_entry(table_e_t'($urandom_range(0, 3)),
				($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40)));
			else if (r < 98) send_word(MODE_WCLEAR, $urandom, table_e_t'($urandom_range(0, 3)),
				9'($urandom));
			else send_word(MODE_FCLEAR, $urandom, table_e_t'($urandom_range(0, 3)),
				9'($urandom));
		end
	endtask

	initial begin
		board.reset_all();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and each class
		sample(32'h0000_0000);
		sample(32'h8000_0000);
		sample(32'h7F80_0000);
		sample(32'hFF80_0000);
		sample(32'h7FFF_FFFF);
		sample(32'hFFC0_0001);
		sample(32'h0000_0001);
		sample(32'h807F_FFFF);
		sample(32'h0080_0000);
		sample(32'h7F7F_FFFF);
		sample(32'hBF80_0000);
		read_entry(TAB_EXP, 9'd254);
		read_entry(TAB_EXP, 9'd511);
		read_entry(TAB_SEEN, 9'd1);
		read_entry(TAB_SEEN, 9'd276);
		read_entry(TAB_SET, 9'd23);
		read_entry(TAB_MANT, 9'd0);
		read_entry(TAB_MANT, 9'd22);
		read_entry(TAB_MANT, 9'd23);
		send_word(MODE_WCLEAR, 32'hFFFF_FFFF, TAB_MANT, 9'h1FF);
		read_entry(TAB_SEEN, 9'd1);
		sample(32'h3F80_0000);
		send_word(MODE_FCLEAR, 32'h0, TAB_EXP, 9'd0);

		random_phase(250);

		// paused gathering
		write_reg(REG_ENABLE, 1'b0);
		random_phase(80);
		write_reg(REG_ENABLE, 1'b1);

		// accumulate mode: window clear has no effect
		write_reg(REG_ACCUM, 1'b1);
		stall_free = 1'b1;
		random_phase(250);
		stall_free = 1'b0;
		write_reg(REG_ACCUM, 1'b0);

		random_phase(500);

		drain();
		if (board.mismatches == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#60ms;
		$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/fbs_pkg.sv
rtl/fbs_ram.sv
rtl/fbs_ctrl.sv
rtl/fbs_datapath.sv
rtl/float_bit_statistics.sv
test/float_bit_statistics_test.sv
